// ===== hdl/bcw_pkg.sv =====
package bcw_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CrcW     = 24;
  localparam int unsigned ChanW    = 6;
  localparam int unsigned CrcBytes = 3;
  localparam int unsigned CntW     = 2;

  localparam logic [CrcW-1:0]  CrcInit     = 24'h555555;
  localparam logic [CrcW-1:0]  CrcPoly     = 24'h00065B;
  localparam logic [ByteW-1:0] LfsrTaps    = 8'h11;
  localparam logic [ByteW-1:0] SeedOrMask  = 8'h02;
  localparam logic [ChanW-1:0] ResetChan   = 6'd37;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_crc;
    logic             end_of_packet;
  } result_t;

  typedef struct packed {
    logic [ByteW-1:0] lfsr;
    logic [ByteW-1:0] data;
  } whiten_t;

  function automatic logic [ByteW-1:0] rev8(logic [ByteW-1:0] v);
    logic [ByteW-1:0] r;
    for (int i = 0; i < ByteW; i++) begin
      r[i] = v[ByteW-1-i];
    end
    return r;
  endfunction

  // The 6-bit channel lands in the top six bits once the byte is reversed.
  function automatic logic [ByteW-1:0] seed_of(logic [ChanW-1:0] chan);
    return rev8({2'b00, chan}) | SeedOrMask;
  endfunction

  function automatic logic [CrcW-1:0] crc_byte(logic [CrcW-1:0] crc, logic [ByteW-1:0] d);
    logic [CrcW-1:0] c;
    logic            top;
    c = crc;
    for (int i = 0; i < ByteW; i++) begin
      top = c[CrcW-1];
      c   = {c[CrcW-2:0], 1'b0};
      if (top != d[i]) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic whiten_t whiten_byte(logic [ByteW-1:0] lfsr, logic [ByteW-1:0] d);
    whiten_t w;
    w.lfsr = lfsr;
    w.data = d;
    for (int i = 0; i < ByteW; i++) begin
      if (w.lfsr[ByteW-1]) begin
        w.lfsr    = w.lfsr ^ LfsrTaps;
        w.data[i] = ~w.data[i];
      end
      w.lfsr = {w.lfsr[ByteW-2:0], 1'b0};
    end
    return w;
  endfunction

endpackage

// ===== hdl/ble_packet_crc_whitener_unit.sv =====
// Channel   Handshake                 Payload
// config    cfg_we_i                  whiten_channel_i[5:0]
// input     in_valid_i / in_ready_o   data_byte_i[7:0], last_byte_i
// output    out_valid_o / out_ready_i out_byte_o[7:0], is_crc_o, end_of_packet_o
//
// Each byte is checked and whitened combinationally and shows up at the output
// in the cycle after its transfer; a byte can be taken every cycle while the
// output is not stalled. A byte marked last is followed by three CRC bytes, one
// per cycle while the output is not stalled, during which no input is taken.
// Reset clears the pending CRC count and output valid; the channel returns to 37.
// A stalled output register holds its byte and stalls the input in the same cycle.
module ble_packet_crc_whitener_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bcw_pkg::ChanW-1:0] whiten_channel_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [bcw_pkg::ByteW-1:0] data_byte_i,
  input  logic                      last_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bcw_pkg::ByteW-1:0] out_byte_o,
  output logic                      is_crc_o,
  output logic                      end_of_packet_o
);
  import bcw_pkg::*;

  logic    res_valid;
  logic    res_free;
  result_t res;

  bcw_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .whiten_channel_i (whiten_channel_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .res_free_i       (res_free),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  bcw_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (res_valid),
    .res_i           (res),
    .res_free_o      (res_free),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .is_crc_o        (is_crc_o),
    .end_of_packet_o (end_of_packet_o)
  );

endmodule

// ===== hdl/bcw_core.sv =====
module bcw_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bcw_pkg::ChanW-1:0] whiten_channel_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [bcw_pkg::ByteW-1:0] data_byte_i,
  input  logic                      last_byte_i,
  input  logic                      res_free_i,
  output logic                      res_valid_o,
  output bcw_pkg::result_t          res_o
);
  import bcw_pkg::*;

  logic [ChanW-1:0] chan_q, chan_d;
  logic [CrcW-1:0]  crc_q, crc_d;
  logic [ByteW-1:0] lfsr_q, lfsr_d;
  logic             open_q, open_d;
  logic [CntW-1:0]  crc_left_q, crc_left_d;

  logic [CrcW-1:0]  crc_base;
  logic [ByteW-1:0] lfsr_base;
  logic [CrcW-1:0]  crc_after;
  whiten_t          wd;
  whiten_t          wc;
  logic             in_xfer;
  logic             crc_emit;

  // A packet start reloads both shift registers before the byte goes through.
  assign crc_base  = open_q ? crc_q : CrcInit;
  assign lfsr_base = open_q ? lfsr_q : seed_of(chan_q);
  assign crc_after = crc_byte(crc_base, data_byte_i);
  assign wd        = whiten_byte(lfsr_base, data_byte_i);
  assign wc        = whiten_byte(lfsr_q, rev8(crc_q[CrcW-1 -: ByteW]));

  assign in_ready_o = (crc_left_q == '0) && res_free_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign crc_emit   = (crc_left_q != '0) && res_free_i;

  always_comb begin
    chan_d      = cfg_we_i ? whiten_channel_i : chan_q;
    crc_d       = crc_q;
    lfsr_d      = lfsr_q;
    open_d      = open_q;
    crc_left_d  = crc_left_q;
    res_valid_o = 1'b0;
    res_o       = '{out_byte: wd.data, is_crc: 1'b0, end_of_packet: 1'b0};
    if (in_xfer) begin
      res_valid_o = 1'b1;
      crc_d       = crc_after;
      lfsr_d      = wd.lfsr;
      open_d      = !last_byte_i;
      if (last_byte_i) begin
        crc_left_d = CntW'(CrcBytes);
      end
    end else if (crc_emit) begin
      res_valid_o = 1'b1;
      res_o       = '{out_byte: wc.data, is_crc: 1'b1,
                      end_of_packet: (crc_left_q == CntW'(1))};
      crc_d       = {crc_q[CrcW-ByteW-1:0], {ByteW{1'b0}}};
      lfsr_d      = wc.lfsr;
      crc_left_d  = crc_left_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q     <= ResetChan;
      crc_q      <= CrcInit;
      lfsr_q     <= seed_of(ResetChan);
      open_q     <= 1'b0;
      crc_left_q <= '0;
    end else begin
      chan_q     <= chan_d;
      crc_q      <= crc_d;
      lfsr_q     <= lfsr_d;
      open_q     <= open_d;
      crc_left_q <= crc_left_d;
    end
  end

endmodule

// ===== hdl/bcw_out_stage.sv =====
module bcw_out_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      res_valid_i,
  input  bcw_pkg::result_t          res_i,
  output logic                      res_free_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bcw_pkg::ByteW-1:0] out_byte_o,
  output logic                      is_crc_o,
  output logic                      end_of_packet_o
);
  import bcw_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  // The register takes a new result when it is empty or its content leaves now.
  assign res_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (res_free_o) begin
      valid_d = res_valid_i;
      res_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o     = valid_q;
  assign out_byte_o      = res_q.out_byte;
  assign is_crc_o        = res_q.is_crc;
  assign end_of_packet_o = res_q.end_of_packet;

endmodule

// ===== hdl/bcw_checker.sv =====
module bcw_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      last_byte_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [bcw_pkg::ByteW-1:0] out_byte_o,
  input logic                      is_crc_o,
  input logic                      end_of_packet_o
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(is_crc_o) && $stable(end_of_packet_o))
    else $error("stalled output changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_packet_o |-> is_crc_o)
    else $error("end of packet on a non-CRC byte");

  // After the last data byte, the CRC bytes block the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_byte_i |=> !in_ready_o)
    else $error("input taken right after last byte");

  // While the first two CRC bytes are on the output, more CRC is still pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_crc_o && !end_of_packet_o |-> !in_ready_o)
    else $error("input taken in the middle of the CRC bytes");

endmodule

bind ble_packet_crc_whitener_unit bcw_checker u_bcw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .last_byte_i     (last_byte_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .out_byte_o      (out_byte_o),
  .is_crc_o        (is_crc_o),
  .end_of_packet_o (end_of_packet_o)
);
